// File: rtl/mqbf_pkg.sv
// mqbf_pkg: shared constants, request codes and item types of the multi-queue byte fifo
// used by every module under rtl; depends on nothing
`default_nettype none

package mqbf_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 256;
    localparam int MAX_BURST   = 16;

    localparam int QID_W    = 2;
    localparam int POS_W    = $clog2(QUEUE_DEPTH);
    localparam int CAP_W    = 9;
    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int BURST_W  = $clog2(MAX_BURST + 1);
    localparam int ADDR_W   = QID_W + POS_W;
    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_CNT_W = 2;

    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [QID_W-1:0]   qid;
        logic [BYTE_W-1:0]  wr_byte;
        logic [BURST_W-1:0] burst;
        logic [CAP_W-1:0]   cap;
    } cmd_t;

    typedef struct packed {
        logic             valid;
        logic [QID_W-1:0] qid;
    } cfg_clr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        logic              byte_valid;
        logic              accepted;
        logic [CAP_W-1:0]  fill_level;
        logic [CAP_W-1:0]  space_left;
        logic              last_of_run;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/mqbf_front.sv
// mqbf_front: capacity registers, input handshake and request classification
// depends on mqbf_pkg; feeds mqbf_cmd_fifo and signals queue clears to mqbf_back
`default_nettype none

module mqbf_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [mqbf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [mqbf_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [mqbf_pkg::QID_W-1:0]        cfg_index,
    input  wire logic [mqbf_pkg::CAP_W-1:0]        cfg_data,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output mqbf_pkg::cmd_t                         push_cmd,
    output mqbf_pkg::cfg_clr_t                     cfg_clr
);

    logic [mqbf_pkg::CAP_W-1:0]   cap_reg [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::CAP_W-1:0]   raw_cap;
    logic [mqbf_pkg::COUNT_W-1:0] rd_count;
    logic [mqbf_pkg::QID_W-1:0]   queue_id;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mqbf_pkg::NUM_QUEUES; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cap_reg[cfg_index] <= cfg_data;
        end
    end

    assign queue_id = s_axis_tuser[3:2];
    assign rd_count = s_axis_tdata[12:8];
    assign raw_cap  = cap_reg[queue_id];

    always_comb
    begin
        push_cmd.req_type = s_axis_tuser[1:0];
        push_cmd.qid      = queue_id;
        push_cmd.wr_byte  = s_axis_tdata[7:0];
        push_cmd.burst    = (rd_count > mqbf_pkg::COUNT_W'(mqbf_pkg::MAX_BURST))
                          ? mqbf_pkg::BURST_W'(mqbf_pkg::MAX_BURST)
                          : mqbf_pkg::BURST_W'(rd_count);
        // capacity above the slice size saturates
        push_cmd.cap      = (raw_cap > mqbf_pkg::CAP_W'(mqbf_pkg::QUEUE_DEPTH))
                          ? mqbf_pkg::CAP_W'(mqbf_pkg::QUEUE_DEPTH)
                          : raw_cap;
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

    assign cfg_clr.valid = cfg_we;
    assign cfg_clr.qid   = cfg_index;

endmodule

`default_nettype wire

// File: rtl/mqbf_cmd_fifo.sv
// mqbf_cmd_fifo: two-entry queue of classified requests between front and back
// depends on mqbf_pkg
`default_nettype none

module mqbf_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mqbf_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop,
    output mqbf_pkg::cmd_t      pop_cmd
);

    mqbf_pkg::cmd_t                   entry_reg [mqbf_pkg::CMDQ_DEPTH];
    logic [mqbf_pkg::CMDQ_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mqbf_pkg::CMDQ_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mqbf_pkg::CMDQ_CNT_W-1:0]  count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != mqbf_pkg::CMDQ_CNT_W'(mqbf_pkg::CMDQ_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mqbf_back.sv
// mqbf_back: queue pointers, shared byte store, request sequencer and output register
// depends on mqbf_pkg; takes requests from mqbf_cmd_fifo
`default_nettype none

module mqbf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_pop,
    input  wire mqbf_pkg::cmd_t     cmd,
    input  wire mqbf_pkg::cfg_clr_t cfg_clr,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mqbf_pkg::result_t       out_data
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic [mqbf_pkg::BYTE_W-1:0] mem [mqbf_pkg::STORE_DEPTH];
    logic [mqbf_pkg::BYTE_W-1:0] rdata_reg;

    logic [mqbf_pkg::POS_W-1:0]  wpos_reg [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::POS_W-1:0]  rpos_reg [mqbf_pkg::NUM_QUEUES];
    logic [mqbf_pkg::CAP_W-1:0]  held_reg [mqbf_pkg::NUM_QUEUES];

    logic                        state_reg, state_next;
    logic [mqbf_pkg::BURST_W-1:0] left_reg, left_next;
    logic [mqbf_pkg::QID_W-1:0]  bq_reg, bq_next;
    logic [mqbf_pkg::CAP_W-1:0]  bcap_reg, bcap_next;
    logic [mqbf_pkg::CAP_W-1:0]  fill_reg, fill_next;
    logic [mqbf_pkg::CAP_W-1:0]  space_reg, space_next;

    logic                        out_valid_reg, out_valid_next;
    mqbf_pkg::result_t           out_data_reg, out_data_next;
    logic                        out_free;
    logic                        out_load;

    logic [mqbf_pkg::QID_W-1:0]  cur_q;
    logic [mqbf_pkg::CAP_W-1:0]  cur_cap;
    logic [mqbf_pkg::POS_W-1:0]  cur_wpos;
    logic [mqbf_pkg::POS_W-1:0]  cur_rpos;
    logic [mqbf_pkg::CAP_W-1:0]  cur_held;
    logic [mqbf_pkg::CAP_W-1:0]  wp_inc;
    logic [mqbf_pkg::CAP_W-1:0]  rp_inc;
    logic [mqbf_pkg::BURST_W-1:0] take_n;

    logic                        ptr_we;
    logic [mqbf_pkg::POS_W-1:0]  wpos_new;
    logic [mqbf_pkg::POS_W-1:0]  rpos_new;
    logic [mqbf_pkg::CAP_W-1:0]  held_new;

    logic                        mem_we;
    logic                        mem_re;
    logic [mqbf_pkg::ADDR_W-1:0] mem_waddr;
    logic [mqbf_pkg::ADDR_W-1:0] mem_raddr;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_q    = (state_reg == ST_BURST) ? bq_reg : cmd.qid;
    assign cur_cap  = (state_reg == ST_BURST) ? bcap_reg : cmd.cap;
    assign cur_wpos = wpos_reg[cur_q];
    assign cur_rpos = rpos_reg[cur_q];
    assign cur_held = held_reg[cur_q];
    assign wp_inc   = {1'b0, cur_wpos} + 1'b1;
    assign rp_inc   = {1'b0, cur_rpos} + 1'b1;
    assign take_n   = (cur_held < mqbf_pkg::CAP_W'(cmd.burst))
                    ? mqbf_pkg::BURST_W'(cur_held) : cmd.burst;
    assign mem_waddr = {cur_q, cur_wpos};
    assign mem_raddr = {cur_q, cur_rpos};

    always_comb
    begin
        state_next    = state_reg;
        left_next     = left_reg;
        bq_next       = bq_reg;
        bcap_next     = bcap_reg;
        fill_next     = fill_reg;
        space_next    = space_reg;
        out_load      = 1'b0;
        out_data_next = out_data_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        ptr_we        = 1'b0;
        wpos_new      = cur_wpos;
        rpos_new      = cur_rpos;
        held_new      = cur_held;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop       = 1'b1;
                    out_load      = 1'b1;
                    out_data_next = '0;
                    out_data_next.last_of_run = 1'b1;
                    if (cmd.cap != '0)
                    begin
                        unique case (cmd.req_type)
                            mqbf_pkg::REQ_WRITE:
                            begin
                                if (cur_held < cmd.cap)
                                begin
                                    mem_we   = 1'b1;
                                    ptr_we   = 1'b1;
                                    wpos_new = (wp_inc == cmd.cap)
                                             ? '0 : wp_inc[mqbf_pkg::POS_W-1:0];
                                    held_new = cur_held + 1'b1;
                                    out_data_next.accepted = 1'b1;
                                end
                                out_data_next.fill_level = held_new;
                                out_data_next.space_left = cmd.cap - held_new;
                            end
                            mqbf_pkg::REQ_READ:
                            begin
                                if (take_n == '0)
                                begin
                                    out_data_next.fill_level = cur_held;
                                    out_data_next.space_left = cmd.cap - cur_held;
                                end
                                else
                                begin
                                    out_load   = 1'b0;
                                    mem_re     = 1'b1;
                                    ptr_we     = 1'b1;
                                    rpos_new   = (rp_inc == cmd.cap)
                                               ? '0 : rp_inc[mqbf_pkg::POS_W-1:0];
                                    held_new   = cur_held - mqbf_pkg::CAP_W'(take_n);
                                    left_next  = take_n;
                                    bq_next    = cmd.qid;
                                    bcap_next  = cmd.cap;
                                    fill_next  = held_new;
                                    space_next = cmd.cap - held_new;
                                    state_next = ST_BURST;
                                end
                            end
                            mqbf_pkg::REQ_CLEAR:
                            begin
                                ptr_we   = 1'b1;
                                wpos_new = '0;
                                rpos_new = '0;
                                held_new = '0;
                                out_data_next.accepted   = 1'b1;
                                out_data_next.space_left = cmd.cap;
                            end
                            mqbf_pkg::REQ_QUERY:
                            begin
                                out_data_next.accepted   = 1'b1;
                                out_data_next.fill_level = cur_held;
                                out_data_next.space_left = cmd.cap - cur_held;
                            end
                            default:
                            begin
                                out_load = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_BURST:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_data_next.rd_byte     = rdata_reg;
                    out_data_next.byte_valid  = 1'b1;
                    out_data_next.accepted    = 1'b1;
                    out_data_next.fill_level  = fill_reg;
                    out_data_next.space_left  = space_reg;
                    out_data_next.last_of_run = (left_reg == mqbf_pkg::BURST_W'(1));
                    left_next = left_reg - 1'b1;
                    if (left_reg == mqbf_pkg::BURST_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_re   = 1'b1;
                        ptr_we   = 1'b1;
                        rpos_new = (rp_inc == bcap_reg)
                                 ? '0 : rp_inc[mqbf_pkg::POS_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < mqbf_pkg::NUM_QUEUES; i++)
            begin
                wpos_reg[i] <= '0;
                rpos_reg[i] <= '0;
                held_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_clr.valid)
            begin
                wpos_reg[cfg_clr.qid] <= '0;
                rpos_reg[cfg_clr.qid] <= '0;
                held_reg[cfg_clr.qid] <= '0;
            end
            else if (ptr_we)
            begin
                wpos_reg[cur_q] <= wpos_new;
                rpos_reg[cur_q] <= rpos_new;
                held_reg[cur_q] <= held_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bq_reg    <= bq_next;
        bcap_reg  <= bcap_next;
        fill_reg  <= fill_next;
        space_reg <= space_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // shared byte store, one slice per queue
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.wr_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_queue_byte_fifo.sv
// multi_queue_byte_fifo: top level of four circular byte queues sharing one byte store
// depends on mqbf_pkg, mqbf_front, mqbf_cmd_fifo and mqbf_back
//
// usage
//   requests enter on the s_axis channel: write a byte, read a burst, clear a queue or
//   query its fill level; each queue's capacity is set through the cfg port, and a
//   capacity write also empties that queue; capacity zero leaves the queue unused
//   results leave on the m_axis channel; a read burst gives one item per byte, with
//   tlast on the final one; every other request gives exactly one item
//   a write, clear or query result passes the request queue and the output register
//   on its way to m_axis; the first byte of a burst also passes the registered read
//   port of the byte store; while a burst runs the back end takes no new request
//   until its last byte is loaded, so later requests wait in the request queue
//   a two-entry request queue keeps s_axis taking items while a result waits on
//   m_axis; when m_axis stalls the result holds, the back end stops, that queue
//   fills, then s_axis_tready drops
//   reset empties every queue and sets every capacity to zero; the byte store itself
//   is not cleared and needs no clearing pass
`default_nettype none

module multi_queue_byte_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // wr_byte[7:0], rd_count[12:8], zero fill
    input  wire logic [mqbf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type[1:0], queue_id[3:2]
    input  wire logic [mqbf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // rd_byte[7:0], fill_level[16:8], space_left[25:17], zero fill
    output logic [mqbf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // byte_valid[0], accepted[1]
    output logic [mqbf_pkg::M_TUSER_W-1:0]      m_axis_tuser,
    output logic                                m_axis_tlast,
    input  wire logic                           cfg_we,
    input  wire logic [mqbf_pkg::QID_W-1:0]     cfg_index,
    input  wire logic [mqbf_pkg::CAP_W-1:0]     cfg_data
);

    logic               push_valid;
    logic               push_ready;
    mqbf_pkg::cmd_t     push_cmd;
    mqbf_pkg::cfg_clr_t cfg_clr;
    logic               cmd_valid;
    logic               cmd_pop;
    mqbf_pkg::cmd_t     cmd;
    mqbf_pkg::result_t  result;

    mqbf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd),
        .cfg_clr       (cfg_clr)
    );

    mqbf_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_cmd    (cmd)
    );

    mqbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cfg_clr   (cfg_clr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    assign m_axis_tdata = {6'd0, result.space_left, result.fill_level, result.rd_byte};
    assign m_axis_tuser = {result.accepted, result.byte_valid};
    assign m_axis_tlast = result.last_of_run;

endmodule

`default_nettype wire
